FILE: rtl/metaphone_phonetic_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// metaphone phonetic encoder assertion macros
// shared concurrent assertion forms, clocked on clk, idle while in reset
// ----------------------------------------------------------------------------
`ifndef METAPHONE_PHONETIC_ENCODER_UNIT_ASSERT_SVH
`define METAPHONE_PHONETIC_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define MPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg
// letter codes, letter property table and shared types of the encoder
// ----------------------------------------------------------------------------
package mpe_pkg;

  localparam int unsigned WIN_DEPTH = 8;   // letters kept in the window
  localparam int unsigned EXT_DEPTH = 11;  // window plus three flush blanks
  localparam int unsigned NUM_CODERS = 4;  // current letter plus three flush slots
  localparam int unsigned BUF_DEPTH = 8;   // most results one word can cause
  localparam int unsigned MAX_POS = 7;

  typedef logic [4:0] letter_t;

  localparam letter_t BLANK        = 5'd31;
  localparam letter_t LETTER_LIMIT = 5'd26;

  localparam letter_t L_A = 5'd0;
  localparam letter_t L_C = 5'd2;
  localparam letter_t L_D = 5'd3;
  localparam letter_t L_E = 5'd4;
  localparam letter_t L_F = 5'd5;
  localparam letter_t L_G = 5'd6;
  localparam letter_t L_H = 5'd7;
  localparam letter_t L_I = 5'd8;
  localparam letter_t L_J = 5'd9;
  localparam letter_t L_K = 5'd10;
  localparam letter_t L_M = 5'd12;
  localparam letter_t L_N = 5'd13;
  localparam letter_t L_O = 5'd14;
  localparam letter_t L_P = 5'd15;
  localparam letter_t L_Q = 5'd16;
  localparam letter_t L_R = 5'd17;
  localparam letter_t L_S = 5'd18;
  localparam letter_t L_T = 5'd19;
  localparam letter_t L_V = 5'd21;
  localparam letter_t L_W = 5'd22;
  localparam letter_t L_X = 5'd23;
  localparam letter_t L_Y = 5'd24;
  localparam letter_t L_Z = 5'd25;
  localparam letter_t L_B = 5'd1;

  localparam logic [7:0] ASCII_A       = 8'h41;
  localparam logic [7:0] ASCII_Z       = 8'h5a;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  // property bits
  localparam int unsigned P_VOWEL  = 0;
  localparam int unsigned P_SAME   = 1;
  localparam int unsigned P_VARSON = 2;
  localparam int unsigned P_FRONTV = 3;
  localparam int unsigned P_NOGHF  = 4;

  localparam logic [4:0] PROP_ROM [26] = '{
    5'd1, 5'd16, 5'd4, 5'd16, 5'd9, 5'd2, 5'd4, 5'd16, 5'd9, 5'd2,
    5'd0, 5'd2,  5'd2, 5'd2,  5'd1, 5'd4, 5'd0, 5'd2,  5'd4, 5'd4,
    5'd1, 5'd0,  5'd0, 5'd0,  5'd8, 5'd0
  };

  // blank and out-of-range codes carry no properties
  function automatic logic [4:0] prop(letter_t c);
    logic [4:0] p;
    p = 5'd0;
    if (c < LETTER_LIMIT) begin
      p = PROP_ROM[c];
    end
    return p;
  endfunction

  function automatic logic [7:0] ascii_of(letter_t c);
    return ASCII_A + {3'b000, c};
  endfunction

  // neighborhood of the letter being coded
  typedef struct packed {
    letter_t w0;   // four letters back
    letter_t pv;
    letter_t cur;
    letter_t n1;
    letter_t n2;
    letter_t n3;
  } coder_in_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] ch0;
    logic [7:0] ch1;
  } coder_out_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic       last;
  } result_t;

endpackage

FILE: rtl/metaphone_phonetic_encoder_unit.sv
// ----------------------------------------------------------------------------
// metaphone_phonetic_encoder_unit
// path: input register, then result buffer, which drives the result stream
// throughput: one byte per cycle while out_tready is high and each byte causes
//   at most one result; else a byte holds the input until its last result leaves
// reset: rst_n low clears the window to blank, the letter count and the queues
// ----------------------------------------------------------------------------
module metaphone_phonetic_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tlast,   // end_of_word
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] code_char
  output logic       out_tuser,  // [0] code_valid
  output logic       out_tlast   // last_code
);

  // --------------------------------------------------------------------------
  // input register: one byte waiting for the coding logic
  // --------------------------------------------------------------------------
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_eow_r;
  logic       advance;

  // result buffer, entry 0 drives the output; shifts down on each taken word
  mpe_pkg::result_t bq_r   [mpe_pkg::BUF_DEPTH];
  mpe_pkg::result_t bq_nxt [mpe_pkg::BUF_DEPTH];
  logic [3:0]       bq_cnt_r, bq_cnt_nxt;
  logic             pop;

  // letter window and saturating letter count
  mpe_pkg::letter_t win_r   [mpe_pkg::WIN_DEPTH];
  mpe_pkg::letter_t win_nxt [mpe_pkg::WIN_DEPTH];
  logic [2:0]       pos_r, pos_nxt;

  // new item may enter once the buffer is empty or its last word leaves now
  assign pop       = out_tvalid && out_tready;
  assign advance   = in_valid_r && ((bq_cnt_r == 4'd0) || (bq_cnt_r == 4'd1 && out_tready));
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eow_r  <= in_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // letter folding
  // --------------------------------------------------------------------------
  logic             is_lower, is_letter;
  logic [7:0]       upper;
  mpe_pkg::letter_t code_in;

  assign is_lower  = (in_byte_r >= mpe_pkg::ASCII_LOWER_A) &&
                     (in_byte_r <= mpe_pkg::ASCII_LOWER_Z);
  assign upper     = is_lower ? (in_byte_r - mpe_pkg::CASE_OFFSET) : in_byte_r;
  assign is_letter = (upper >= mpe_pkg::ASCII_A) && (upper <= mpe_pkg::ASCII_Z);
  assign code_in   = 5'(upper - mpe_pkg::ASCII_A);

  // --------------------------------------------------------------------------
  // window shift, start-of-word rules and the single-x fix
  // --------------------------------------------------------------------------
  mpe_pkg::letter_t w_sh [mpe_pkg::WIN_DEPTH];
  mpe_pkg::letter_t w1   [mpe_pkg::WIN_DEPTH];
  mpe_pkg::letter_t w2   [mpe_pkg::WIN_DEPTH];
  mpe_pkg::letter_t ext  [mpe_pkg::EXT_DEPTH];
  logic [2:0]       pos_inc, pos1;
  mpe_pkg::letter_t st_a, st_b;

  assign pos_inc = (pos_r < 3'(mpe_pkg::MAX_POS)) ? (pos_r + 3'd1) : pos_r;
  assign st_a    = win_r[mpe_pkg::WIN_DEPTH - 1];  // first letter after the shift
  assign st_b    = code_in;                        // second letter

  always_comb begin
    for (int i = 0; i < mpe_pkg::WIN_DEPTH - 1; i++) begin
      w_sh[i] = win_r[i + 1];
    end
    w_sh[mpe_pkg::WIN_DEPTH - 1] = code_in;

    if (pos_inc == 3'd2) begin
      // pn kn gn ae wr drop the first letter, wh becomes w, initial x sounds s
      priority if (((st_a == mpe_pkg::L_P || st_a == mpe_pkg::L_K || st_a == mpe_pkg::L_G) &&
                    st_b == mpe_pkg::L_N) ||
                   (st_a == mpe_pkg::L_A && st_b == mpe_pkg::L_E) ||
                   (st_a == mpe_pkg::L_W && st_b == mpe_pkg::L_R)) begin
        w_sh[mpe_pkg::WIN_DEPTH - 2] = mpe_pkg::BLANK;
      end else if (st_a == mpe_pkg::L_W && st_b == mpe_pkg::L_H) begin
        w_sh[mpe_pkg::WIN_DEPTH - 1] = mpe_pkg::L_W;
        w_sh[mpe_pkg::WIN_DEPTH - 2] = mpe_pkg::BLANK;
      end else if (st_a == mpe_pkg::L_X) begin
        w_sh[mpe_pkg::WIN_DEPTH - 2] = mpe_pkg::L_S;
      end else begin
        w_sh[mpe_pkg::WIN_DEPTH - 2] = st_a;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < mpe_pkg::WIN_DEPTH; i++) begin
      w1[i] = is_letter ? w_sh[i] : win_r[i];
    end
    pos1 = is_letter ? pos_inc : pos_r;

    // one-letter word x codes as s at the flush
    for (int i = 0; i < mpe_pkg::WIN_DEPTH; i++) begin
      w2[i] = w1[i];
    end
    if (in_eow_r && pos1 == 3'd1 && w1[mpe_pkg::WIN_DEPTH - 1] == mpe_pkg::L_X) begin
      w2[mpe_pkg::WIN_DEPTH - 1] = mpe_pkg::L_S;
    end

    // flush view: window followed by blanks
    for (int i = 0; i < mpe_pkg::WIN_DEPTH; i++) begin
      ext[i] = w2[i];
    end
    for (int i = mpe_pkg::WIN_DEPTH; i < mpe_pkg::EXT_DEPTH; i++) begin
      ext[i] = mpe_pkg::BLANK;
    end
  end

  // --------------------------------------------------------------------------
  // four coders: the new letter in slot 4, then slots 5..7 on end of word
  // --------------------------------------------------------------------------
  mpe_pkg::coder_in_t  cin  [mpe_pkg::NUM_CODERS];
  mpe_pkg::coder_out_t cout [mpe_pkg::NUM_CODERS];
  logic                cen  [mpe_pkg::NUM_CODERS];

  always_comb begin
    cin[0] = '{w0: w1[0], pv: w1[3], cur: w1[4], n1: w1[5], n2: w1[6], n3: w1[7]};
    cen[0] = is_letter;
    for (int k = 1; k < mpe_pkg::NUM_CODERS; k++) begin
      cin[k] = '{w0: ext[k], pv: ext[k + 3], cur: ext[k + 4],
                 n1: ext[k + 5], n2: ext[k + 6], n3: ext[k + 7]};
      cen[k] = in_eow_r;
    end
  end

  for (genvar g = 0; g < mpe_pkg::NUM_CODERS; g++) begin : g_coder
    mpe_coder u_coder (
      .nb  (cin[g]),
      .res (cout[g])
    );
  end

  // --------------------------------------------------------------------------
  // pack the code letters in order, mark the last one or the empty key
  // --------------------------------------------------------------------------
  mpe_pkg::result_t res_buf [mpe_pkg::BUF_DEPTH];
  logic [3:0]       total;

  always_comb begin
    logic [3:0] off;
    logic [3:0] last_idx;
    for (int i = 0; i < mpe_pkg::BUF_DEPTH; i++) begin
      res_buf[i] = '0;
    end
    off = 4'd0;
    for (int j = 0; j < mpe_pkg::NUM_CODERS; j++) begin
      if (cen[j] && cout[j].cnt != 2'd0) begin
        res_buf[off[2:0]] = '{ch: cout[j].ch0, vld: 1'b1, last: 1'b0};
        off = off + 4'd1;
        if (cout[j].cnt == 2'd2) begin
          res_buf[off[2:0]] = '{ch: cout[j].ch1, vld: 1'b1, last: 1'b0};
          off = off + 4'd1;
        end
      end
    end
    total    = off;
    last_idx = off - 4'd1;
    if (in_eow_r) begin
      if (off == 4'd0) begin
        res_buf[0] = '{ch: 8'd0, vld: 1'b0, last: 1'b1};  // empty key
        total      = 4'd1;
      end else begin
        res_buf[last_idx[2:0]].last = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // state update and result buffer
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < mpe_pkg::WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end
    pos_nxt = pos_r;
    if (advance) begin
      for (int i = 0; i < mpe_pkg::WIN_DEPTH; i++) begin
        win_nxt[i] = in_eow_r ? mpe_pkg::BLANK : w1[i];
      end
      pos_nxt = in_eow_r ? 3'd0 : pos1;
    end
  end

  always_comb begin
    for (int i = 0; i < mpe_pkg::BUF_DEPTH; i++) begin
      bq_nxt[i] = bq_r[i];
    end
    bq_cnt_nxt = bq_cnt_r;
    if (advance) begin
      for (int i = 0; i < mpe_pkg::BUF_DEPTH; i++) begin
        bq_nxt[i] = res_buf[i];
      end
      bq_cnt_nxt = total;
    end else if (pop) begin
      for (int i = 0; i < mpe_pkg::BUF_DEPTH - 1; i++) begin
        bq_nxt[i] = bq_r[i + 1];
      end
      bq_cnt_nxt = bq_cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mpe_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= mpe_pkg::BLANK;
      end
      pos_r    <= 3'd0;
      bq_cnt_r <= 4'd0;
    end else begin
      for (int i = 0; i < mpe_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
      pos_r    <= pos_nxt;
      bq_cnt_r <= bq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < mpe_pkg::BUF_DEPTH; i++) begin
      bq_r[i] <= bq_nxt[i];
    end
  end

  assign out_tvalid = (bq_cnt_r != 4'd0);
  assign out_tdata  = bq_r[0].ch;
  assign out_tuser  = bq_r[0].vld;
  assign out_tlast  = bq_r[0].last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `include "metaphone_phonetic_encoder_unit_assert.svh"

  logic head_blank;
  assign head_blank = (win_r[mpe_pkg::WIN_DEPTH - 1] == mpe_pkg::BLANK);

  `MPE_ASSERT_NOW(a_buf_bound, 1'b1, bq_cnt_r <= 4'(mpe_pkg::BUF_DEPTH), "buffer overfilled")
  `MPE_ASSERT_NOW(a_empty_is_last, out_tvalid && !out_tuser, out_tlast, "empty key not last")
  `MPE_ASSERT_NOW(a_idle_window, pos_r == 3'd0, head_blank, "window not blank at word start")
  `MPE_ASSERT_NEXT(a_item_held, in_valid_r && bq_cnt_r > 4'd1, in_valid_r, "pending byte lost")

endmodule

FILE: rtl/mpe_coder.sv
// ----------------------------------------------------------------------------
// mpe_coder
// letter rules for one window position, zero to two code letters
// ----------------------------------------------------------------------------
module mpe_coder (
  input  mpe_pkg::coder_in_t  nb,
  output mpe_pkg::coder_out_t res
);

  logic start;
  logic [4:0] p_cur, p_pv, p_n1, p_n2;

  assign start = (nb.pv == mpe_pkg::BLANK);
  assign p_cur = mpe_pkg::prop(nb.cur);
  assign p_pv  = mpe_pkg::prop(nb.pv);
  assign p_n1  = mpe_pkg::prop(nb.n1);
  assign p_n2  = mpe_pkg::prop(nb.n2);

  always_comb begin
    res = '0;
    priority if (nb.cur >= mpe_pkg::LETTER_LIMIT) begin
      res = '0;
    end else if (nb.pv == nb.cur && nb.cur != mpe_pkg::L_C) begin
      res = '0;  // doubled letter
    end else if (p_cur[mpe_pkg::P_SAME] || (start && p_cur[mpe_pkg::P_VOWEL])) begin
      res.cnt = 2'd1;
      res.ch0 = mpe_pkg::ascii_of(nb.cur);
    end else begin
      unique case (nb.cur)
        mpe_pkg::L_B: begin
          // final mb
          if (!(nb.n1 == mpe_pkg::BLANK && nb.pv == mpe_pkg::L_M)) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_B);
          end
        end
        mpe_pkg::L_C: begin
          if (nb.pv != mpe_pkg::L_S || !p_n1[mpe_pkg::P_FRONTV]) begin
            res.cnt = 2'd1;
            priority if (nb.n1 == mpe_pkg::L_I && nb.n2 == mpe_pkg::L_A) begin
              res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_X);
            end else if (p_n1[mpe_pkg::P_FRONTV]) begin
              res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_S);
            end else if (nb.n1 == mpe_pkg::L_H) begin
              res.ch0 = ((start && !p_n2[mpe_pkg::P_VOWEL]) || nb.pv == mpe_pkg::L_S) ?
                        mpe_pkg::ascii_of(mpe_pkg::L_K) : mpe_pkg::ascii_of(mpe_pkg::L_X);
            end else begin
              res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_K);
            end
          end
        end
        mpe_pkg::L_D: begin
          res.cnt = 2'd1;
          res.ch0 = (nb.n1 == mpe_pkg::L_G && p_n2[mpe_pkg::P_FRONTV]) ?
                    mpe_pkg::ascii_of(mpe_pkg::L_J) : mpe_pkg::ascii_of(mpe_pkg::L_T);
        end
        mpe_pkg::L_G: begin
          if ((nb.n1 != mpe_pkg::L_H || p_n2[mpe_pkg::P_VOWEL]) &&
              (nb.n1 != mpe_pkg::L_N || (nb.n2 != mpe_pkg::BLANK &&
                (nb.n2 != mpe_pkg::L_E || nb.n3 != mpe_pkg::L_D))) &&
              (nb.pv != mpe_pkg::L_D || !p_n1[mpe_pkg::P_FRONTV])) begin
            res.cnt = 2'd1;
            res.ch0 = (p_n1[mpe_pkg::P_FRONTV] && nb.n2 != mpe_pkg::L_G) ?
                      mpe_pkg::ascii_of(mpe_pkg::L_J) : mpe_pkg::ascii_of(mpe_pkg::L_K);
          end else if (nb.n1 == mpe_pkg::L_H && !p_pv[mpe_pkg::P_NOGHF] &&
                       nb.w0 != mpe_pkg::L_H) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_F);
          end
        end
        mpe_pkg::L_H: begin
          if (!p_pv[mpe_pkg::P_VARSON] &&
              (!p_pv[mpe_pkg::P_VOWEL] || p_n1[mpe_pkg::P_VOWEL])) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_H);
          end
        end
        mpe_pkg::L_K: begin
          if (nb.pv != mpe_pkg::L_C) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_K);
          end
        end
        mpe_pkg::L_P: begin
          res.cnt = 2'd1;
          res.ch0 = (nb.n1 == mpe_pkg::L_H) ?
                    mpe_pkg::ascii_of(mpe_pkg::L_F) : mpe_pkg::ascii_of(mpe_pkg::L_P);
        end
        mpe_pkg::L_Q: begin
          res.cnt = 2'd1;
          res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_K);
        end
        mpe_pkg::L_S: begin
          res.cnt = 2'd1;
          res.ch0 = (nb.n1 == mpe_pkg::L_H || (nb.n1 == mpe_pkg::L_I &&
                    (nb.n2 == mpe_pkg::L_O || nb.n2 == mpe_pkg::L_A))) ?
                    mpe_pkg::ascii_of(mpe_pkg::L_X) : mpe_pkg::ascii_of(mpe_pkg::L_S);
        end
        mpe_pkg::L_T: begin
          priority if (nb.n1 == mpe_pkg::L_I &&
                       (nb.n2 == mpe_pkg::L_O || nb.n2 == mpe_pkg::L_A)) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_X);
          end else if (nb.n1 == mpe_pkg::L_H) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_O);  // th
          end else if (nb.n1 != mpe_pkg::L_C || nb.n2 != mpe_pkg::L_H) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_T);
          end else begin
            res.cnt = 2'd0;  // tch
          end
        end
        mpe_pkg::L_V: begin
          res.cnt = 2'd1;
          res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_F);
        end
        mpe_pkg::L_W, mpe_pkg::L_Y: begin
          if (p_n1[mpe_pkg::P_VOWEL]) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(nb.cur);
          end
        end
        mpe_pkg::L_X: begin
          if (start) begin
            res.cnt = 2'd1;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_S);
          end else begin
            res.cnt = 2'd2;
            res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_K);
            res.ch1 = mpe_pkg::ascii_of(mpe_pkg::L_S);
          end
        end
        mpe_pkg::L_Z: begin
          res.cnt = 2'd1;
          res.ch0 = mpe_pkg::ascii_of(mpe_pkg::L_S);
        end
        default: begin
          res = '0;  // non-initial vowels and the rest are silent
        end
      endcase
    end
  end

endmodule
